FILE: sv/arq_pkg.sv
// shared types and constants of the active/expired run queue
// no dependencies; imported by the top level and the port checker
package arq_pkg;

    localparam int ACTION_W = 3;
    localparam int ID_W     = 8;
    localparam int TIME_W   = 32;
    localparam int SLICE_W  = 40;
    localparam int STATUS_W = 2;
    localparam int ID_COUNT = 256;

    // action codes of an input transaction
    localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ERASE   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CHARGE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ADMIT   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    localparam logic [TIME_W-1:0]  TIME_SLICE_RESET = 32'd10000000;
    localparam logic [SLICE_W-1:0] SLICE_MIN        = 40'h80_0000_0000;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENQ,
        ST_DEQ,
        ST_DEQ_OUT,
        ST_ER_START,
        ST_ER_BACK,
        ST_ER_SCAN,
        ST_ER_SHIFT,
        ST_CHARGE,
        ST_ADMIT,
        ST_FINISH
    } state_t;

endpackage

FILE: sv/active_expired_run_queue_top.sv
// Admit, enqueue and charge go through their own state to ST_FINISH, dequeue through ST_DEQ
// and, if not empty, ST_DEQ_OUT; an unknown action straight to ST_FINISH. A new transaction
// is taken once the result is in the output register. Erase walks the queues one entry
// a cycle through the single queue memory read port, active queue first. A result waiting in
// the output register holds the block. Reset (aresetn low, synchronous): both queues empty,
// queue a active, time_slice at its default; entries and slices undefined until written.
module active_expired_run_queue_top #(
    parameter int MAX_TASKS   = 256,
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [arq_pkg::TIME_W-1:0]    cfg_wr_data,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [arq_pkg::ACTION_W-1:0]  s_action,
    input  logic [arq_pkg::ID_W-1:0]      s_task_id,
    input  logic                          s_boost,
    input  logic [arq_pkg::TIME_W-1:0]    s_elapsed_time,
    input  logic                          s_off_cpu,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [arq_pkg::ID_W-1:0]      m_task_out,
    output logic                          m_task_valid,
    output logic                          m_slice_expired,
    output logic [arq_pkg::STATUS_W-1:0]  m_status
);

    import arq_pkg::*;

    localparam int SLOT_W     = $clog2(MAX_TASKS);
    localparam int QW         = $clog2(QUEUE_DEPTH);
    localparam int CW         = $clog2(QUEUE_DEPTH + 1);
    localparam int QMEM_DEPTH = 2 << QW;

    state_t state_reg, state_next;

    logic [TIME_W-1:0] time_slice_reg;

    logic          a_is_active_reg, a_is_active_next;
    logic [CW-1:0] count_a_reg, count_a_next, count_b_reg, count_b_next;
    logic [QW-1:0] head_a_reg, head_a_next, head_b_reg, head_b_next;

    // transaction held while it is worked on
    logic [ID_W-1:0]   id_reg;
    logic              boost_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic              off_cpu_reg;

    // erase walk
    logic          er_q_reg, er_q_next;
    logic          er_second_reg, er_second_next;
    logic [QW-1:0] pos_reg, pos_next;

    // pending result
    logic [ID_W-1:0]     res_task_out_reg, res_task_out_next;
    logic                res_task_valid_reg, res_task_valid_next;
    logic                res_expired_reg, res_expired_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    // output register
    logic                m_valid_reg;
    logic [ID_W-1:0]     m_task_out_reg;
    logic                m_task_valid_reg;
    logic                m_slice_expired_reg;
    logic [STATUS_W-1:0] m_status_reg;

    // queue memory and slice table ports
    logic            q_wr_en;
    logic [QW:0]     q_wr_addr, q_rd_addr;
    logic [ID_W-1:0] q_wr_data, q_rdata;
    logic               sl_wr_en;
    logic [SLICE_W-1:0] sl_wr_data, sl_rdata;
    logic [SLOT_W-1:0]  sl_rd_addr, sl_wr_addr;

    // target queue selection
    logic          act_q, exp_q, tgt_q;
    logic [CW-1:0] act_count, exp_count, tgt_count, tgt_count_next;
    logic [QW-1:0] tgt_head, tgt_head_next, head_dec, head_inc;
    logic          slice_pos, hit, pos_last, pass_fail, out_free, s_accept;

    // charge arithmetic
    logic [SLICE_W:0]   charge_diff;
    logic [SLICE_W-1:0] charge_new;

    logic [SLOT_W-1:0] slot_lut [ID_COUNT];
    logic [ID_W-1:0]   slot_id;

    // task id to slice table slot
    for (genvar g = 0; g < ID_COUNT; g++) begin : g_slot
        assign slot_lut[g] = SLOT_W'(g % MAX_TASKS);
    end

    // logical queue position to memory address
    function automatic logic [QW-1:0] phys_addr(input logic [QW-1:0] head,
                                                input logic [CW-1:0] offs);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(offs);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[QW-1:0];
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // storage
    arq_ram #(
        .DEPTH(QMEM_DEPTH),
        .WIDTH(ID_W)
    ) u_queue_mem (
        .clk    (aclk),
        .wr_en  (q_wr_en),
        .wr_addr(q_wr_addr),
        .wr_data(q_wr_data),
        .rd_addr(q_rd_addr),
        .rd_data(q_rdata)
    );

    arq_ram #(
        .DEPTH(MAX_TASKS),
        .WIDTH(SLICE_W)
    ) u_slice_mem (
        .clk    (aclk),
        .wr_en  (sl_wr_en),
        .wr_addr(sl_wr_addr),
        .wr_data(sl_wr_data),
        .rd_addr(sl_rd_addr),
        .rd_data(sl_rdata)
    );

    // slice table addressing
    assign slot_id    = (state_reg == ST_IDLE) ? s_task_id : id_reg;
    assign sl_rd_addr = slot_lut[slot_id];
    assign sl_wr_addr = slot_lut[id_reg];

    // queue roles and the queue the current state works on
    assign act_q     = ~a_is_active_reg;
    assign exp_q     = a_is_active_reg;
    assign act_count = act_q ? count_b_reg : count_a_reg;
    assign exp_count = exp_q ? count_b_reg : count_a_reg;
    assign slice_pos = !sl_rdata[SLICE_W-1] && (sl_rdata != '0);

    always_comb begin
        case (state_reg)
            ST_ENQ:  tgt_q = slice_pos ? act_q : exp_q;
            ST_DEQ:  tgt_q = (act_count == '0) ? exp_q : act_q;
            default: tgt_q = er_q_reg;
        endcase
    end

    assign tgt_count = tgt_q ? count_b_reg : count_a_reg;
    assign tgt_head  = tgt_q ? head_b_reg : head_a_reg;
    assign head_dec  = (tgt_head == '0) ? QW'(QUEUE_DEPTH - 1) : tgt_head - QW'(1);
    assign head_inc  = (tgt_head == QW'(QUEUE_DEPTH - 1)) ? '0 : tgt_head + QW'(1);

    // erase walk conditions
    assign hit      = (q_rdata == id_reg);
    assign pos_last = ((CW'(pos_reg) + CW'(2)) == tgt_count);
    always_comb begin
        case (state_reg)
            ST_ER_START: pass_fail = (tgt_count == '0);
            ST_ER_BACK:  pass_fail = !hit && (tgt_count == CW'(1));
            ST_ER_SCAN:  pass_fail = !hit && pos_last;
            default:     pass_fail = 1'b0;
        endcase
    end

    // charge: subtract and saturate at the most negative slice
    assign charge_diff = {sl_rdata[SLICE_W-1], sl_rdata}
                       - {{(SLICE_W + 1 - TIME_W){1'b0}}, elapsed_reg};
    assign charge_new  = (charge_diff[SLICE_W] != charge_diff[SLICE_W-1])
                       ? SLICE_MIN : charge_diff[SLICE_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_action)
                        ACT_ENQUEUE: state_next = ST_ENQ;
                        ACT_DEQUEUE: state_next = ST_DEQ;
                        ACT_ERASE:   state_next = ST_ER_START;
                        ACT_CHARGE:  state_next = ST_CHARGE;
                        ACT_ADMIT:   state_next = ST_ADMIT;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_ENQ: state_next = ST_FINISH;
            ST_DEQ: begin
                if (act_count == '0 && exp_count == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_DEQ_OUT;
                end
            end
            ST_DEQ_OUT: state_next = ST_FINISH;
            ST_ER_START: begin
                if (pass_fail) begin
                    state_next = er_second_reg ? ST_FINISH : ST_ER_START;
                end else begin
                    state_next = ST_ER_BACK;
                end
            end
            ST_ER_BACK: begin
                if (hit) begin
                    state_next = ST_FINISH;
                end else if (pass_fail) begin
                    state_next = er_second_reg ? ST_FINISH : ST_ER_START;
                end else begin
                    state_next = ST_ER_SCAN;
                end
            end
            ST_ER_SCAN: begin
                if (hit) begin
                    state_next = ST_ER_SHIFT;
                end else if (pass_fail) begin
                    state_next = er_second_reg ? ST_FINISH : ST_ER_START;
                end
            end
            ST_ER_SHIFT: begin
                if (pos_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_CHARGE: state_next = ST_FINISH;
            ST_ADMIT:  state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control per state
    always_comb begin
        a_is_active_next    = a_is_active_reg;
        head_a_next         = head_a_reg;
        head_b_next         = head_b_reg;
        count_a_next        = count_a_reg;
        count_b_next        = count_b_reg;
        tgt_head_next       = tgt_head;
        tgt_count_next      = tgt_count;
        er_q_next           = er_q_reg;
        er_second_next      = er_second_reg;
        pos_next            = pos_reg;
        res_task_out_next   = res_task_out_reg;
        res_task_valid_next = res_task_valid_reg;
        res_expired_next    = res_expired_reg;
        res_status_next     = res_status_reg;
        q_wr_en             = 1'b0;
        q_wr_addr           = {tgt_q, phys_addr(tgt_head, CW'(pos_reg))};
        q_wr_data           = id_reg;
        q_rd_addr           = {tgt_q, tgt_head};
        sl_wr_en            = 1'b0;
        sl_wr_data          = {{(SLICE_W - TIME_W){1'b0}}, time_slice_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_task_out_next   = '0;
                    res_task_valid_next = 1'b0;
                    res_expired_next    = 1'b0;
                    res_status_next     = STATUS_OK;
                    er_q_next           = act_q;
                    er_second_next      = 1'b0;
                end
            end
            ST_ENQ: begin
                if (tgt_count == CW'(QUEUE_DEPTH)) begin
                    res_status_next = STATUS_FULL;
                end else begin
                    // push at front or back, refill when the task had no slice left
                    q_wr_en        = 1'b1;
                    tgt_count_next = tgt_count + CW'(1);
                    if (boost_reg) begin
                        tgt_head_next = head_dec;
                        q_wr_addr     = {tgt_q, head_dec};
                    end else begin
                        q_wr_addr = {tgt_q, phys_addr(tgt_head, tgt_count)};
                    end
                    sl_wr_en = !slice_pos;
                end
            end
            ST_DEQ: begin
                if (act_count == '0 && exp_count == '0) begin
                    res_status_next = STATUS_EMPTY;
                end else begin
                    // swap roles when only the expired queue holds tasks, then pop front
                    if (act_count == '0) begin
                        a_is_active_next = ~a_is_active_reg;
                    end
                    q_rd_addr      = {tgt_q, tgt_head};
                    tgt_head_next  = head_inc;
                    tgt_count_next = tgt_count - CW'(1);
                end
            end
            ST_DEQ_OUT: begin
                res_task_out_next   = q_rdata;
                res_task_valid_next = 1'b1;
            end
            ST_ER_START: begin
                // look at the back entry first
                q_rd_addr = {tgt_q, phys_addr(tgt_head, tgt_count - CW'(1))};
            end
            ST_ER_BACK: begin
                if (hit) begin
                    tgt_count_next = tgt_count - CW'(1);
                end else begin
                    q_rd_addr = {tgt_q, tgt_head};
                    pos_next  = '0;
                end
            end
            ST_ER_SCAN: begin
                q_rd_addr = {tgt_q, phys_addr(tgt_head, CW'(pos_reg) + CW'(1))};
                if (!hit && !pos_last) begin
                    pos_next = pos_reg + QW'(1);
                end
            end
            ST_ER_SHIFT: begin
                // close the gap: move the next entry one place toward the front
                q_wr_en   = 1'b1;
                q_wr_data = q_rdata;
                if (pos_last) begin
                    tgt_count_next = tgt_count - CW'(1);
                end else begin
                    q_rd_addr = {tgt_q, phys_addr(tgt_head, CW'(pos_reg) + CW'(2))};
                    pos_next  = pos_reg + QW'(1);
                end
            end
            ST_CHARGE: begin
                sl_wr_en         = 1'b1;
                sl_wr_data       = charge_new;
                res_expired_next = !off_cpu_reg
                                && (charge_new[SLICE_W-1] || (charge_new == '0));
            end
            ST_ADMIT: begin
                sl_wr_en = 1'b1;
            end
            ST_FINISH: begin
            end
            default: begin
            end
        endcase

        // end of one erase pass without a match
        if (pass_fail) begin
            if (er_second_reg) begin
                res_status_next = STATUS_NOT_FOUND;
            end else begin
                er_q_next      = ~er_q_reg;
                er_second_next = 1'b1;
            end
        end

        // route the target queue update
        if (tgt_q) begin
            head_b_next  = tgt_head_next;
            count_b_next = tgt_count_next;
        end else begin
            head_a_next  = tgt_head_next;
            count_a_next = tgt_count_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            time_slice_reg  <= TIME_SLICE_RESET;
            a_is_active_reg <= 1'b1;
            count_a_reg     <= '0;
            count_b_reg     <= '0;
            head_a_reg      <= '0;
            head_b_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            a_is_active_reg <= a_is_active_next;
            count_a_reg     <= count_a_next;
            count_b_reg     <= count_b_next;
            head_a_reg      <= head_a_next;
            head_b_reg      <= head_b_next;
            if (cfg_wr_en) begin
                time_slice_reg <= cfg_wr_data;
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            id_reg      <= s_task_id;
            boost_reg   <= s_boost;
            elapsed_reg <= s_elapsed_time;
            off_cpu_reg <= s_off_cpu;
        end
        er_q_reg           <= er_q_next;
        er_second_reg      <= er_second_next;
        pos_reg            <= pos_next;
        res_task_out_reg   <= res_task_out_next;
        res_task_valid_reg <= res_task_valid_next;
        res_expired_reg    <= res_expired_next;
        res_status_reg     <= res_status_next;
        if (state_reg == ST_FINISH && out_free) begin
            m_task_out_reg      <= res_task_out_reg;
            m_task_valid_reg    <= res_task_valid_reg;
            m_slice_expired_reg <= res_expired_reg;
            m_status_reg        <= res_status_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_task_out      = m_task_out_reg;
    assign m_task_valid    = m_task_valid_reg;
    assign m_slice_expired = m_slice_expired_reg;
    assign m_status        = m_status_reg;

endmodule

FILE: sv/arq_ram.sv
// simple dual-port memory: one write port, one registered read port
// no dependencies; used for the queue storage and the slice table
module arq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/arq_checker.sv
// port-level checks for the run queue top level, attached by bind
// depends on arq_pkg for the status codes
module arq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [arq_pkg::ID_W-1:0]      m_task_out,
    input logic                          m_task_valid,
    input logic                          m_slice_expired,
    input logic [arq_pkg::STATUS_W-1:0]  m_status
);

    import arq_pkg::*;

    // one transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a transaction is in work");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_task_out) && $stable(m_status))
        else $error("result changed while stalled");

    // a popped task comes with ok status and no expiry
    a_pop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_task_valid |-> m_status == STATUS_OK && !m_slice_expired)
        else $error("dequeue result carries other flags");

    // no task id without a pop
    a_task_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_task_valid |-> m_task_out == '0)
        else $error("task id without a popped task");

    // no expiry flag with an error status
    a_expiry_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> !m_slice_expired)
        else $error("expiry reported with error status");

endmodule

bind active_expired_run_queue_top arq_checker u_arq_checker (.*);
